### hdl/gsm7_septet_unpack_to_utf8_top_assert.svh
// Assertion macros for the septet unpacker.
`ifndef GSM7_SEPTET_UNPACK_TO_UTF8_TOP_ASSERT_SVH
`define GSM7_SEPTET_UNPACK_TO_UTF8_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GSM7U_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GSM7U_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/gsm7u_pkg.sv
`default_nettype none
package gsm7u_pkg;

  localparam int unsigned SeptetSlots = 3;

  typedef struct packed {
    logic [7:0] octet;
    logic       first_octet;
    logic       last_octet;
    logic [7:0] septet_total;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       last_of_run;
    logic       message_end;
    logic       length_error;
  } out_item_t;

  typedef struct packed {
    logic [SeptetSlots-1:0][6:0] septets;
    logic [1:0]                  count;
    logic                        last;
    logic                        len_err;
  } sep_grp_t;

  localparam logic [10:0] GSM_ROM [128] = '{
    11'h040, 11'h0A3, 11'h024, 11'h0A5, 11'h0E8, 11'h0E9, 11'h0F9, 11'h0EC,
    11'h0F2, 11'h0C7, 11'h00A, 11'h0D8, 11'h0F8, 11'h00D, 11'h0C5, 11'h0E5,
    11'h394, 11'h05F, 11'h3A6, 11'h393, 11'h39B, 11'h3A9, 11'h3A0, 11'h3A8,
    11'h3A3, 11'h398, 11'h39E, 11'h000, 11'h0C6, 11'h0E6, 11'h0DF, 11'h0C9,
    11'h020, 11'h021, 11'h022, 11'h023, 11'h0A4, 11'h025, 11'h026, 11'h027,
    11'h028, 11'h029, 11'h02A, 11'h02B, 11'h02C, 11'h02D, 11'h02E, 11'h02F,
    11'h030, 11'h031, 11'h032, 11'h033, 11'h034, 11'h035, 11'h036, 11'h037,
    11'h038, 11'h039, 11'h03A, 11'h03B, 11'h03C, 11'h03D, 11'h03E, 11'h03F,
    11'h0A1, 11'h041, 11'h042, 11'h043, 11'h044, 11'h045, 11'h046, 11'h047,
    11'h048, 11'h049, 11'h04A, 11'h04B, 11'h04C, 11'h04D, 11'h04E, 11'h04F,
    11'h050, 11'h051, 11'h052, 11'h053, 11'h054, 11'h055, 11'h056, 11'h057,
    11'h058, 11'h059, 11'h05A, 11'h0C4, 11'h0D6, 11'h0D1, 11'h0DC, 11'h0A7,
    11'h0BF, 11'h061, 11'h062, 11'h063, 11'h064, 11'h065, 11'h066, 11'h067,
    11'h068, 11'h069, 11'h06A, 11'h06B, 11'h06C, 11'h06D, 11'h06E, 11'h06F,
    11'h070, 11'h071, 11'h072, 11'h073, 11'h074, 11'h075, 11'h076, 11'h077,
    11'h078, 11'h079, 11'h07A, 11'h0E4, 11'h0F6, 11'h0F1, 11'h0FC, 11'h0E0
  };

  localparam logic [8:0] CountMax = 9'd511;

endpackage
`default_nettype wire

### hdl/gsm7u_unpack.sv
`default_nettype none
module gsm7u_unpack (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  gsm7u_pkg::in_item_t item,
  output gsm7u_pkg::sep_grp_t grp
);
  import gsm7u_pkg::*;

  logic [7:0]  prev_r, prev_nxt;
  logic [2:0]  shift_r, shift_nxt;
  logic [8:0]  count_r, count_nxt;

  logic [8:0]  base;
  logic [15:0] pair_sh;
  logic [7:0]  flush_sh;
  logic [6:0]  s_main;
  logic [1:0]  n_main;
  logic [9:0]  sum1;
  logic [8:0]  c1;
  logic        flush;

  always_comb begin
    base     = item.first_octet ? 9'd0 : count_r;
    pair_sh  = {item.octet, prev_r} >> (4'd8 - {1'b0, shift_r});
    if (item.first_octet) begin
      s_main    = item.octet[6:0];
      n_main    = 2'd1;
      shift_nxt = 3'd1;
    end else if (shift_r == 3'd7) begin
      s_main    = pair_sh[6:0];
      n_main    = 2'd2;
      shift_nxt = 3'd1;
    end else begin
      s_main    = pair_sh[6:0];
      n_main    = 2'd1;
      shift_nxt = shift_r + 3'd1;
    end
    sum1     = {1'b0, base} + {8'd0, n_main};
    c1       = sum1[9] ? CountMax : sum1[8:0];
    flush    = item.last_octet && (c1 < {1'b0, item.septet_total});
    flush_sh = item.octet >> (4'd8 - {1'b0, shift_nxt});
    if (flush && c1 != CountMax) begin
      count_nxt = c1 + 9'd1;
    end else begin
      count_nxt = c1;
    end
    prev_nxt = item.octet;

    grp.septets[0] = s_main;
    grp.septets[1] = (n_main == 2'd2) ? item.octet[6:0] : flush_sh[6:0];
    grp.septets[2] = flush_sh[6:0];
    grp.count      = n_main + {1'b0, flush};
    grp.last       = item.last_octet;
    grp.len_err    = count_nxt != {1'b0, item.septet_total};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      shift_r <= 3'd1;
      count_r <= '0;
    end else if (load) begin
      prev_r  <= prev_nxt;
      shift_r <= shift_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/gsm7u_serial.sv
`default_nettype none
module gsm7u_serial (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  gsm7u_pkg::sep_grp_t  grp,
  output logic                 ready,
  output logic                 busy,
  input  logic                 out_stall,
  output logic                 out_valid,
  output gsm7u_pkg::out_item_t out_data
);
  import gsm7u_pkg::*;

  logic      work_valid_r, work_valid_nxt;
  sep_grp_t  grp_r;
  logic [1:0] idx_r, idx_nxt;
  logic      half_r, half_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic [6:0]  cur_s;
  logic [10:0] cp;
  logic        wide;
  logic        sep_done;
  logic        final_byte;
  logic        out_free;
  logic        advance;
  logic [7:0]  byte_val;

  always_comb begin
    cur_s      = grp_r.septets[idx_r];
    cp         = GSM_ROM[cur_s];
    wide       = cp[10:7] != 4'd0;
    sep_done   = !wide || half_r;
    final_byte = sep_done && (idx_r == grp_r.count - 2'd1);
    out_free   = !out_valid_r || !out_stall;
    advance    = work_valid_r && out_free;
    ready      = !work_valid_r || (advance && final_byte);

    if (!wide) begin
      byte_val = cp[7:0];
    end else if (half_r) begin
      byte_val = {2'b10, cp[5:0]};
    end else begin
      byte_val = {3'b110, cp[10:6]};
    end

    work_valid_nxt = work_valid_r;
    idx_nxt        = idx_r;
    half_nxt       = half_r;
    if (load) begin
      work_valid_nxt = 1'b1;
      idx_nxt        = 2'd0;
      half_nxt       = 1'b0;
    end else if (advance) begin
      if (final_byte) begin
        work_valid_nxt = 1'b0;
      end
      if (sep_done) begin
        idx_nxt  = idx_r + 2'd1;
        half_nxt = 1'b0;
      end else begin
        half_nxt = 1'b1;
      end
    end

    out_data_nxt.utf8_byte    = byte_val;
    out_data_nxt.last_of_run  = final_byte;
    out_data_nxt.message_end  = final_byte && grp_r.last;
    out_data_nxt.length_error = final_byte && grp_r.last && grp_r.len_err;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      idx_r        <= '0;
      half_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      idx_r        <= idx_nxt;
      half_r       <= half_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign busy      = work_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### hdl/gsm7_septet_unpack_to_utf8_top.sv
// Unpacks GSM 7-bit packed user-data octets into septets, maps each septet through the
// default alphabet and sends the text as UTF-8 bytes, one byte per output transaction.
// An octet produces one to three septets of one or two bytes each, which leave in turn
// through the single byte-wide output register; octets that decode to one byte each are
// taken at one per cycle while the output does not stall. The septets are registered in
// the serializer and each byte in the output register. The escape code yields a 0x00
// byte, and the length error flag is valid only on the byte that carries message_end.
`default_nettype none
`include "gsm7_septet_unpack_to_utf8_top_assert.svh"
module gsm7_septet_unpack_to_utf8_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gsm7u_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gsm7u_pkg::out_item_t out_data
);
  import gsm7u_pkg::*;

  sep_grp_t grp;
  logic     ser_ready;
  logic     ser_busy;
  logic     load;

  assign in_stall = !ser_ready;
  assign load     = in_valid && ser_ready;

  gsm7u_unpack u_unpack (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .item  (in_data),
    .grp   (grp)
  );

  gsm7u_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .grp       (grp),
    .ready     (ser_ready),
    .busy      (ser_busy),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `GSM7U_ASSERT_SAME(a_end_is_final, clk, rst_n,
    out_valid && out_data.message_end, out_data.last_of_run,
    "message end on a byte that does not close its run")
  `GSM7U_ASSERT_SAME(a_err_at_end, clk, rst_n,
    out_valid && out_data.length_error, out_data.message_end,
    "length error away from message end")
  `GSM7U_ASSERT_NEXT(a_accept_fills, clk, rst_n,
    in_valid && !in_stall, ser_busy,
    "accepted transaction did not reach the serializer")

endmodule
`default_nettype wire
